[sv/cbpa_pkg.sv]
// Package for the contiguous page bitmap allocator.
// Holds word types, status and opcode codes, and sizing constants.
// No dependencies.
package cbpa_pkg;

    // Default map size in pages
    localparam int PAGES_DEFAULT = 512;
    // Pages held by one cell of the ring
    localparam int CELL_BITS     = 8;
    // Width of internal page numbers, counts and range bounds
    localparam int CNT_W         = 14;
    // Width of the zone registers and of the configuration data
    localparam int CFG_W         = 10;

    typedef enum logic [0:0] {
        OP_ALLOC   = 1'b0,
        OP_RESERVE = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BAD   = 2'd1,
        ST_NORUN = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_LOW_FIRST    = 2'd0,
        REG_LOW_END      = 2'd1,
        REG_NORMAL_FIRST = 2'd2,
        REG_NORMAL_END   = 2'd3
    } reg_index_t;

    // Command word
    typedef struct packed {
        logic       opcode;
        logic       zone_select;
        logic [9:0] page_count;
        logic [8:0] first_page;
    } cmd_t;

    // Result word
    typedef struct packed {
        logic [1:0] status;
        logic [8:0] start_page;
    } result_t;

    // Control handed from the sequencer to the head of the ring
    typedef struct packed {
        logic             marking;
        logic [CNT_W-1:0] zone_lo;
        logic [CNT_W-1:0] zone_hi;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] mark_lo;
        logic [CNT_W-1:0] mark_hi;
    } head_ctrl_t;

    // Run tracking state carried from group to group
    typedef struct packed {
        logic             found;
        logic [CNT_W-1:0] run;
        logic [CNT_W-1:0] start;
    } scan_state_t;

endpackage

[sv/cbpa_cell.sv]
// One cell of the bitmap ring: holds the used bits of CELL_BITS pages.
// Depends on cbpa_pkg.
module cbpa_cell
    import cbpa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 shift,
    input  logic [CELL_BITS-1:0] d,
    output logic [CELL_BITS-1:0] q
);

    logic [CELL_BITS-1:0] bits_reg;

    // Take the neighbour's bits on every shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg <= '0;
        end
        else if (shift)
        begin
            bits_reg <= d;
        end
    end

    assign q = bits_reg;

endmodule

[sv/cbpa_head.sv]
// Head of the ring: run tracking over one group of pages, or range marking.
// Depends on cbpa_pkg.
module cbpa_head
    import cbpa_pkg::*;
(
    input  logic [CNT_W-1:0]     base_page,
    input  logic [CELL_BITS-1:0] bits_in,
    input  head_ctrl_t           ctrl,
    input  scan_state_t          scan_in,
    output logic [CELL_BITS-1:0] bits_out,
    output scan_state_t          scan_out
);

    logic [CNT_W-1:0] page;
    scan_state_t      s;

    always_comb
    begin
        s        = scan_in;
        bits_out = bits_in;
        page     = base_page;
        for (int i = 0; i < CELL_BITS; i++)
        begin
            page = base_page + CNT_W'(i);
            if (ctrl.marking)
            begin
                // set bits inside the marked range
                if (page >= ctrl.mark_lo && page < ctrl.mark_hi)
                begin
                    bits_out[i] = 1'b1;
                end
            end
            else if (!s.found && page >= ctrl.zone_lo && page < ctrl.zone_hi)
            begin
                // first-fit run tracking inside the zone
                if (bits_in[i])
                begin
                    s.run = '0;
                end
                else
                begin
                    s.run = s.run + 1'b1;
                    if (s.run == ctrl.count)
                    begin
                        s.found = 1'b1;
                        s.start = page + 1'b1 - ctrl.count;
                    end
                end
            end
        end
        scan_out = s;
    end

endmodule

[sv/contiguous_page_bitmap_allocator.sv]
// Contiguous page bitmap allocator, first fit, top level.
// Usage:
//   A command word on cmd is taken at a rising edge with start high and
//   busy low. busy stays high until the result has been shown.
//   The result word appears on result for exactly one cycle with done high;
//   the receiver cannot stall it, so it must take it in that cycle.
//   The used-page map sits in a ring of PAGES/8 cells of 8 pages each. The
//   ring turns one cell per cycle while scanning or marking, past a head
//   unit that tracks free runs or marks pages.
//   Sequence from the accepted command to the done cycle:
//     allocate, run found:      one turn to search, one turn to mark the run
//     allocate, no free run:    one turn to search
//     reserve:                  one turn to mark the range
//     allocate with bad count or empty zone: straight to the result
//   One command at a time; a new command is taken only after the result.
//   Zone registers are written through cfg_we / cfg_index / cfg_data at any
//   edge, and should only change while busy is low.
//   Reset clears the whole map (every page free) and loads the default zones.
// Depends on cbpa_pkg, cbpa_cell and cbpa_head.
module contiguous_page_bitmap_allocator
    import cbpa_pkg::*;
#(
    parameter int PAGES = PAGES_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  cmd_t                cmd,
    output logic                done,
    output result_t             result,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_W-1:0]    cfg_data
);

    localparam int NG = PAGES / CELL_BITS;
    localparam int GW = $clog2(NG);
    localparam int GB = $clog2(CELL_BITS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_MARK = 4'b0100,
        S_RESP = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [GW-1:0]     group_reg, group_next;
    logic [CFG_W-1:0]  low_first_reg, low_end_reg, norm_first_reg, norm_end_reg;
    head_ctrl_t        ctrl_reg, ctrl_next;
    scan_state_t       scan_reg, scan_next;
    logic [1:0]        status_reg, status_next;
    logic [CNT_W-1:0]  start_reg, start_next;

    logic [CELL_BITS-1:0] cell_q [NG];
    logic [CELL_BITS-1:0] head_out;
    scan_state_t          head_scan;
    logic                 shift;
    logic                 last_group;
    logic [CNT_W-1:0]     base_page;
    logic [CNT_W-1:0]     zone_lo, zone_end, zone_hi, req_count, res_end;
    logic                 accept;

    // Zone registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_first_reg  <= CFG_W'(0);
            low_end_reg    <= CFG_W'(8);
            norm_first_reg <= CFG_W'(8);
            norm_end_reg   <= CFG_W'(512);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LOW_FIRST:    low_first_reg  <= cfg_data;
                REG_LOW_END:      low_end_reg    <= cfg_data;
                REG_NORMAL_FIRST: norm_first_reg <= cfg_data;
                REG_NORMAL_END:   norm_end_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Ring of cells; the head output feeds the tail
    assign shift = (state_reg == S_SCAN) || (state_reg == S_MARK);

    for (genvar g = 0; g < NG; g++)
    begin : g_cell
        logic [CELL_BITS-1:0] d;
        if (g == NG - 1)
        begin : g_tail
            assign d = head_out;
        end
        else
        begin : g_mid
            assign d = cell_q[g+1];
        end
        cbpa_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (shift),
            .d     (d),
            .q     (cell_q[g])
        );
    end

    assign base_page = CNT_W'({group_reg, GB'(0)});

    cbpa_head u_head (
        .base_page (base_page),
        .bits_in   (cell_q[0]),
        .ctrl      (ctrl_reg),
        .scan_in   (scan_reg),
        .bits_out  (head_out),
        .scan_out  (head_scan)
    );

    // Command decode
    assign accept    = start && (state_reg == S_IDLE);
    assign zone_lo   = CNT_W'(cmd.zone_select ? norm_first_reg : low_first_reg);
    assign zone_end  = CNT_W'(cmd.zone_select ? norm_end_reg : low_end_reg);
    assign zone_hi   = (zone_end > CNT_W'(PAGES)) ? CNT_W'(PAGES) : zone_end;
    assign req_count = CNT_W'(cmd.page_count);
    assign res_end   = (CNT_W'(cmd.first_page) + req_count > CNT_W'(PAGES)) ?
                       CNT_W'(PAGES) : CNT_W'(cmd.first_page) + req_count;
    assign last_group = (group_reg == GW'(NG - 1));

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        group_next  = group_reg;
        ctrl_next   = ctrl_reg;
        scan_next   = scan_reg;
        status_next = status_reg;
        start_next  = start_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    group_next        = '0;
                    scan_next         = '0;
                    start_next        = '0;
                    status_next       = ST_OK;
                    ctrl_next.zone_lo = zone_lo;
                    ctrl_next.zone_hi = zone_hi;
                    ctrl_next.count   = req_count;
                    if (cmd.opcode == OP_RESERVE)
                    begin
                        ctrl_next.marking = 1'b1;
                        ctrl_next.mark_lo = CNT_W'(cmd.first_page);
                        ctrl_next.mark_hi = res_end;
                        state_next        = S_MARK;
                    end
                    else if (req_count == '0 || req_count > CNT_W'(PAGES) ||
                             zone_lo >= zone_hi)
                    begin
                        status_next = ST_BAD;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        ctrl_next.marking = 1'b0;
                        state_next        = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                scan_next  = head_scan;
                group_next = last_group ? '0 : group_reg + 1'b1;
                if (last_group)
                begin
                    if (head_scan.found)
                    begin
                        ctrl_next.marking = 1'b1;
                        ctrl_next.mark_lo = head_scan.start;
                        ctrl_next.mark_hi = head_scan.start + ctrl_reg.count;
                        start_next        = head_scan.start;
                        state_next        = S_MARK;
                    end
                    else
                    begin
                        status_next = ST_NORUN;
                        state_next  = S_RESP;
                    end
                end
            end
            S_MARK:
            begin
                group_next = last_group ? '0 : group_reg + 1'b1;
                if (last_group)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            group_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            group_reg <= group_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ctrl_reg   <= ctrl_next;
        scan_reg   <= scan_next;
        status_reg <= status_next;
        start_reg  <= start_next;
    end

    assign busy              = (state_reg != S_IDLE);
    assign done              = (state_reg == S_RESP);
    assign result.status     = status_reg;
    assign result.start_page = start_reg[8:0];

endmodule

[sv/cbpa_checker.sv]
// Port-level checks for the allocator, bound onto the top level.
// Depends on cbpa_pkg and contiguous_page_bitmap_allocator.
module cbpa_checker
    import cbpa_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input result_t          result
);

    // a taken command makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after command taken");

    // a result word only shows while busy
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done outside a command");

    // one result word per command
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result word repeated");

    // busy only drops after the result word
    a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(done))
        else $error("busy dropped without result");

    // failed allocations carry start page zero
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != ST_OK |-> result.start_page == '0)
        else $error("non-zero start page on failure");

endmodule

bind contiguous_page_bitmap_allocator cbpa_checker u_cbpa_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
